>>> rtl/go_back_n_receiver_defines.svh
// Assertion macros for the go-back-n receiver
`ifndef GO_BACK_N_RECEIVER_DEFINES_SVH
`define GO_BACK_N_RECEIVER_DEFINES_SVH
`ifndef SYNTH
`define GBNR_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define GBNR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GBNR_ASSERT(lbl, expr, msg)
`define GBNR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/gbnr_pkg.sv
package gbnr_pkg;

    localparam int MAX_CHUNKS  = 4096;
    localparam int CHUNK_BYTES = 4096;

    // last storable chunk slot and length of a full chunk
    localparam logic [11:0] SLOT_LIMIT =
        12'(((MAX_CHUNKS > 4096) ? 4096 : MAX_CHUNKS) - 1);
    localparam logic [12:0] FULL_LEN =
        13'((CHUNK_BYTES > 8191) ? 8191 : CHUNK_BYTES);

    localparam logic CFG_ACK_EVERY = 1'b0;
    localparam logic CFG_TIMEOUT   = 1'b1;

    localparam logic [4:0]  ACK_EVERY_RST = 5'd1;
    localparam logic [15:0] TIMEOUT_RST   = 16'd50;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_BAD,
        KIND_PKT
    } kind_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_CONNECT = 3'd1,
        EV_FIN     = 3'd2,
        EV_DONE    = 3'd3,
        EV_TIMEOUT = 3'd4
    } event_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] seq_num;
        logic        pkt_syn;
        logic        pkt_fin;
        logic        pkt_str;
        logic        pkt_end;
        logic        pkt_cont;
        logic [11:0] chunk_total;
        logic [12:0] final_len;
    } item_t;

    // first member is the top bit: send_ack ends up at bit 0 of tdata
    typedef struct packed {
        logic [2:0]  session_event;
        logic        file_error;
        logic        file_done;
        logic [12:0] chunk_len;
        logic [11:0] chunk_index;
        logic        store_chunk;
        logic        ack_resend;
        logic [15:0] ack_num;
        logic        send_ack;
    } result_t;

endpackage

>>> rtl/gbnr_front.sv
module gbnr_front
(
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [47:0]         s_axis_tdata,
    input  logic [4:0]          s_axis_tuser,
    input  logic                s_axis_tlast,
    input  logic                q_full,
    output logic                push,
    output gbnr_pkg::item_t     item
);
    import gbnr_pkg::*;

    logic [12:0] flen;

    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;
    assign flen          = s_axis_tdata[41:29];

    always_comb
    begin
        if (s_axis_tuser[0])
        begin
            item.kind = KIND_TICK;
        end
        else if (!s_axis_tdata[0])
        begin
            item.kind = KIND_BAD;
        end
        else
        begin
            item.kind = KIND_PKT;
        end
        item.seq_num     = s_axis_tdata[16:1];
        item.pkt_syn     = s_axis_tuser[1];
        item.pkt_fin     = s_axis_tuser[2];
        item.pkt_str     = s_axis_tuser[3];
        item.pkt_end     = s_axis_tlast;
        item.pkt_cont    = s_axis_tuser[4];
        item.chunk_total = s_axis_tdata[28:17];
        item.final_len   = (flen > FULL_LEN) ? FULL_LEN : flen;
    end

endmodule

>>> rtl/gbnr_queue.sv
module gbnr_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  gbnr_pkg::item_t     item_in,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output gbnr_pkg::item_t     head
);
    import gbnr_pkg::*;

    item_t      mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/gbnr_back.sv
`include "go_back_n_receiver_defines.svh"

module gbnr_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [15:0]         cfg_wdata,
    input  logic                head_valid,
    input  gbnr_pkg::item_t     head,
    output logic                pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [55:0]         m_axis_tdata
);
    import gbnr_pkg::*;

    logic [4:0]  ack_every_reg;
    logic [15:0] timeout_reg;

    logic [1:0]  mode_reg;
    logic [1:0]  mode_next;
    logic [15:0] exp_reg;
    logic [15:0] exp_next;
    logic [4:0]  ack_cnt_reg;
    logic [4:0]  ack_cnt_next;
    logic [11:0] chunks_seen_reg;
    logic [11:0] chunks_seen_next;
    logic [11:0] last_idx_reg;
    logic [11:0] last_idx_next;
    logic [12:0] last_len_reg;
    logic [12:0] last_len_next;
    logic        ends_sess_reg;
    logic        ends_sess_next;
    logic [15:0] idle_reg;
    logic [15:0] idle_next;
    logic        ovf_reg;
    logic        ovf_next;

    logic        out_valid_reg;
    result_t     out_data_reg;
    result_t     res;

    logic [4:0]  eff_every;
    logic [4:0]  cnt_inc;
    logic [15:0] idle_inc;
    logic        close;
    logic        on;
    logic        sending;
    logic        fire;

    assign pop           = head_valid && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_data_reg};

    assign eff_every = (ack_every_reg == 5'd0) ? 5'd1 : ack_every_reg;
    assign cnt_inc   = ack_cnt_reg + 5'd1;
    assign idle_inc  = (idle_reg != 16'hFFFF) ? idle_reg + 16'd1 : idle_reg;
    assign on        = mode_reg[0];
    assign sending   = mode_reg[1];
    assign fire      = (cnt_inc >= eff_every) || head.pkt_end;

    always_comb
    begin
        mode_next        = mode_reg;
        exp_next         = exp_reg;
        ack_cnt_next     = ack_cnt_reg;
        chunks_seen_next = chunks_seen_reg;
        last_idx_next    = last_idx_reg;
        last_len_next    = last_len_reg;
        ends_sess_next   = ends_sess_reg;
        idle_next        = idle_reg;
        ovf_next         = ovf_reg;
        res              = '0;
        close            = 1'b0;

        case (head.kind)
            KIND_TICK:
            begin
                idle_next = idle_inc;
                if (on && idle_inc >= timeout_reg && exp_reg != 16'd0)
                begin
                    close             = 1'b1;
                    res.session_event = EV_TIMEOUT;
                end
            end
            KIND_PKT:
            begin
                if (head.seq_num != exp_reg)
                begin
                    res.send_ack   = 1'b1;
                    res.ack_num    = exp_reg - 16'd1;
                    res.ack_resend = 1'b1;
                end
                else
                begin
                    // data words inside a file are acked cumulatively
                    if (sending && !head.pkt_str)
                    begin
                        res.send_ack = fire;
                        ack_cnt_next = fire ? 5'd0 : cnt_inc;
                    end
                    else
                    begin
                        res.send_ack = 1'b1;
                    end
                    res.ack_num = res.send_ack ? exp_reg : 16'd0;
                    idle_next   = 16'd0;
                    exp_next    = exp_reg + 16'd1;

                    if (mode_reg == 2'b00 && head.pkt_syn)
                    begin
                        mode_next         = 2'b01;
                        res.session_event = EV_CONNECT;
                    end
                    else if (on && head.pkt_fin)
                    begin
                        close             = 1'b1;
                        res.session_event = EV_FIN;
                    end
                    else if (on && !sending && head.pkt_str)
                    begin
                        mode_next      = 2'b11;
                        ends_sess_next = head.pkt_cont;
                        last_idx_next  = head.chunk_total;
                        last_len_next  = head.final_len;
                    end
                    else if (on && sending && head.pkt_end)
                    begin
                        mode_next = 2'b01;
                        if (chunks_seen_reg != last_idx_reg || ovf_reg)
                        begin
                            res.file_error = 1'b1;
                            ends_sess_next = 1'b0;
                        end
                        else
                        begin
                            res.store_chunk = 1'b1;
                            res.chunk_index = last_idx_reg;
                            res.chunk_len   = last_len_reg;
                            res.file_done   = 1'b1;
                            if (ends_sess_reg)
                            begin
                                close             = 1'b1;
                                res.session_event = EV_DONE;
                            end
                        end
                        chunks_seen_next = 12'd0;
                        ovf_next         = 1'b0;
                    end
                    else if (on && sending)
                    begin
                        if (chunks_seen_reg < SLOT_LIMIT)
                        begin
                            res.store_chunk  = 1'b1;
                            res.chunk_index  = chunks_seen_reg;
                            res.chunk_len    = FULL_LEN;
                            chunks_seen_next = chunks_seen_reg + 12'd1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                res.send_ack   = 1'b1;
                res.ack_num    = exp_reg - 16'd1;
                res.ack_resend = 1'b1;
            end
        endcase

        if (close)
        begin
            mode_next        = 2'b00;
            exp_next         = 16'd0;
            ack_cnt_next     = eff_every - 5'd1;
            chunks_seen_next = 12'd0;
            last_idx_next    = 12'd0;
            last_len_next    = 13'd0;
            ends_sess_next   = 1'b0;
            idle_next        = 16'd0;
            ovf_next         = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_every_reg   <= ACK_EVERY_RST;
            timeout_reg     <= TIMEOUT_RST;
            mode_reg        <= 2'b00;
            exp_reg         <= 16'd0;
            ack_cnt_reg     <= ACK_EVERY_RST - 5'd1;
            chunks_seen_reg <= 12'd0;
            last_idx_reg    <= 12'd0;
            last_len_reg    <= 13'd0;
            ends_sess_reg   <= 1'b0;
            idle_reg        <= 16'd0;
            ovf_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_ACK_EVERY: ack_every_reg <= cfg_wdata[4:0];
                    CFG_TIMEOUT:   timeout_reg   <= cfg_wdata;
                    default:       ;
                endcase
            end
            if (pop)
            begin
                mode_reg        <= mode_next;
                exp_reg         <= exp_next;
                ack_cnt_reg     <= ack_cnt_next;
                chunks_seen_reg <= chunks_seen_next;
                last_idx_reg    <= last_idx_next;
                last_len_reg    <= last_len_next;
                ends_sess_reg   <= ends_sess_next;
                idle_reg        <= idle_next;
                ovf_reg         <= ovf_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // sending without an open connection never happens
    `GBNR_ASSERT(a_mode_legal, mode_reg != 2'b10, "sending flag set while connection off")
    `GBNR_ASSERT(a_resend_acks,
        !(out_valid_reg && out_data_reg.ack_resend && !out_data_reg.send_ack),
        "repeat ack without ack")
    `GBNR_ASSERT(a_chunk_bound, chunks_seen_reg <= SLOT_LIMIT, "chunk count past last slot")
    `GBNR_ASSERT_NEXT(a_close_clears, pop && close,
        exp_reg == 16'd0 && mode_reg == 2'b00, "session end left state behind")

endmodule

>>> rtl/go_back_n_receiver.sv
// Go-back-N receiver: one packet header or idle tick per word.
// Throughput: one word per cycle when the output side keeps taking results.
// Each word passes through a queue slot and then the output register before its
// result is offered on the output side.
// A two-word queue between decode and state update absorbs output stalls.
// Reset (rst_n, asynchronous, active low) clears the session state, ack_every 1, timeout 50.
module go_back_n_receiver
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // checksum_ok, seq_num[15:0], chunk_total[11:0], final_len[12:0], zero pad
    input  logic [47:0] s_axis_tdata,
    // opcode, SYN, FIN, STR, continue
    input  logic [4:0]  s_axis_tuser,
    // END
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // send_ack, ack_num[15:0], ack_resend, store_chunk, chunk_index[11:0],
    // chunk_len[12:0], file_done, file_error, session_event[2:0], zero pad
    output logic [55:0] m_axis_tdata
);
    import gbnr_pkg::*;

    item_t item;
    item_t head;
    logic  push;
    logic  q_full;
    logic  pop;
    logic  head_valid;

    gbnr_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .push          (push),
        .item          (item)
    );

    gbnr_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item_in    (item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    gbnr_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

>>> bench/go_back_n_receiver_tb.sv
`timescale 1ns / 100ps

module go_back_n_receiver_tb;

    import gbnr_pkg::*;

    localparam bit OP_PKT  = 1'b0;
    localparam bit OP_TICK = 1'b1;
    localparam int ON_BIT   = 0;
    localparam int SEND_BIT = 1;
    localparam int MAX_GAP     = 16;
    localparam int HOLD_CYCLES = 120;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_SHOWN   = 10;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 85;

    typedef struct {
        bit        opcode;
        bit        checksum_ok;
        bit [15:0] seq_num;
        bit        pkt_syn;
        bit        pkt_fin;
        bit        pkt_str;
        bit        pkt_end;
        bit        pkt_cont;
        bit [11:0] chunk_total;
        bit [12:0] final_len;
    } header_t;

    // Tracks the connection as the receiver should see it and holds the replies due
    class link_tracker;
        bit [4:0]  ack_every;
        bit [15:0] timeout_ticks;
        bit [1:0]  mode;
        bit [15:0] exp_seq;
        bit [4:0]  ack_cnt;
        bit [11:0] seen;
        bit [11:0] last_idx;
        bit [12:0] last_len;
        bit        ends_sess;
        bit [15:0] idle;
        bit        overflow;
        result_t   due[$];
        int        faults;

        function new();
            ack_every     = ACK_EVERY_RST;
            timeout_ticks = TIMEOUT_RST;
            faults        = 0;
            drop_session();
        endfunction

        function bit [4:0] ack_period();
            return (ack_every == 5'd0) ? 5'd1 : ack_every;
        endfunction

        function void drop_session();
            mode      = '0;
            exp_seq   = '0;
            ack_cnt   = ack_period() - 5'd1;
            seen      = '0;
            last_idx  = '0;
            last_len  = '0;
            ends_sess = 1'b0;
            idle      = '0;
            overflow  = 1'b0;
        endfunction

        function void write_reg(logic addr, logic [15:0] value);
            if (addr == CFG_ACK_EVERY)
                ack_every = value[4:0];
            else
                timeout_ticks = value;
        endfunction

        function void take_word(header_t h);
            result_t   r;
            bit [15:0] cur;
            bit        advance;
            r = '0;
            if (h.opcode == OP_TICK)
            begin
                if (idle != 16'hFFFF)
                    idle = idle + 16'd1;
                if (mode[ON_BIT] && idle >= timeout_ticks && exp_seq != 16'd0)
                begin
                    drop_session();
                    r.session_event = EV_TIMEOUT;
                end
            end
            else if (!h.checksum_ok || h.seq_num != exp_seq)
            begin
                // rejected: repeat the ack for the last in-order word
                r.send_ack   = 1'b1;
                r.ack_num    = exp_seq - 16'd1;
                r.ack_resend = 1'b1;
            end
            else
            begin
                cur     = exp_seq;
                advance = 1'b1;
                if (mode[SEND_BIT] && !h.pkt_str)
                begin
                    ack_cnt = ack_cnt + 5'd1;
                    if (ack_cnt >= ack_period() || h.pkt_end)
                    begin
                        r.send_ack = 1'b1;
                        ack_cnt    = '0;
                    end
                end
                else
                    r.send_ack = 1'b1;
                if (r.send_ack)
                    r.ack_num = cur;
                idle = '0;

                if (mode == 2'b00 && h.pkt_syn)
                begin
                    mode[ON_BIT]    = 1'b1;
                    r.session_event = EV_CONNECT;
                end
                else if (mode[ON_BIT] && h.pkt_fin)
                begin
                    drop_session();
                    r.session_event = EV_FIN;
                    advance         = 1'b0;
                end
                else if (mode[ON_BIT] && !mode[SEND_BIT] && h.pkt_str)
                begin
                    mode[SEND_BIT] = 1'b1;
                    ends_sess      = h.pkt_cont;
                    last_idx       = h.chunk_total;
                    last_len       = (h.final_len > FULL_LEN) ? FULL_LEN : h.final_len;
                end
                else if (mode[ON_BIT] && mode[SEND_BIT] && h.pkt_end)
                begin
                    mode[SEND_BIT] = 1'b0;
                    if (seen != last_idx || overflow)
                    begin
                        r.file_error = 1'b1;
                        ends_sess    = 1'b0;
                    end
                    else
                    begin
                        r.store_chunk = 1'b1;
                        r.chunk_index = last_idx;
                        r.chunk_len   = last_len;
                        r.file_done   = 1'b1;
                        if (ends_sess)
                        begin
                            drop_session();
                            r.session_event = EV_DONE;
                            advance         = 1'b0;
                        end
                    end
                    seen     = '0;
                    overflow = 1'b0;
                end
                else if (mode[ON_BIT] && mode[SEND_BIT])
                begin
                    if (seen < SLOT_LIMIT)
                    begin
                        r.store_chunk = 1'b1;
                        r.chunk_index = seen;
                        r.chunk_len   = FULL_LEN;
                        seen          = seen + 12'd1;
                    end
                    else
                        overflow = 1'b1;
                end

                if (advance)
                    exp_seq = cur + 16'd1;
            end
            due.push_back(r);
        endfunction

        function string show(result_t r);
            return {$sformatf("ack %0b/%0d resend %0b store %0b idx %0d ",
                              r.send_ack, r.ack_num, r.ack_resend, r.store_chunk, r.chunk_index),
                    $sformatf("len %0d done %0b err %0b ev %0d",
                              r.chunk_len, r.file_done, r.file_error, r.session_event)};
        endfunction

        function void check_reply(result_t got);
            result_t want;
            if (due.size() == 0)
            begin
                faults++;
                if (faults <= MAX_SHOWN)
                    $display("unexpected reply: %s", show(got));
                return;
            end
            want = due.pop_front();
            if (got.send_ack !== want.send_ack || got.ack_num !== want.ack_num ||
                got.ack_resend !== want.ack_resend || got.store_chunk !== want.store_chunk ||
                got.chunk_index !== want.chunk_index || got.chunk_len !== want.chunk_len ||
                got.file_done !== want.file_done || got.file_error !== want.file_error ||
                got.session_event !== want.session_event)
            begin
                faults++;
                if (faults <= MAX_SHOWN)
                begin
                    $display("reply mismatch at %0t", $realtime);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;  // checksum_ok, seq_num, chunk_total, final_len, pad
    logic [4:0]  s_axis_tuser = '0;  // opcode, SYN, FIN, STR, continue
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // send_ack, ack_num, ack_resend, store_chunk, chunk_index, chunk_len,
    // file_done, file_error, session_event, pad
    logic [55:0] m_axis_tdata;

    link_tracker tracker = new();

    bit src_burst  = 1'b0;
    bit sink_burst = 1'b0;
    bit hold_out   = 1'b0;
    int quiet_cycles = 0;

    bit [4:0]  ack_plan [PHASES] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd16, 5'd2, 5'd5, 5'd1, 5'd7};
    bit [15:0] tmo_plan [PHASES] = '{16'd50, 16'd1, 16'd65535, 16'd0, 16'd3, 16'd65535,
                                     16'd8, 16'd20, 16'd2, 16'd5};

    go_back_n_receiver u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_reply(result_t'(m_axis_tdata[48:0]));
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("no handshake for %0d cycles", quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // reply side: random stalls, and one long hold-off on request
    initial
    begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_out)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_out = 1'b0;
            end
            stall = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    function automatic header_t pkt(bit syn, bit fin, bit str, bit fend, bit cont,
                                    bit [11:0] ctot, bit [12:0] flen);
        header_t h;
        h.opcode      = OP_PKT;
        h.checksum_ok = 1'b1;
        h.seq_num     = tracker.exp_seq;
        h.pkt_syn     = syn;
        h.pkt_fin     = fin;
        h.pkt_str     = str;
        h.pkt_end     = fend;
        h.pkt_cont    = cont;
        h.chunk_total = ctot;
        h.final_len   = flen;
        return h;
    endfunction

    function automatic header_t random_word();
        header_t h;
        int      pick;
        int      roll;
        pick = $urandom_range(0, 99);
        roll = $urandom_range(0, 99);
        h = pkt(1'b0, 1'b0, 1'b0, 1'b0, 1'($urandom_range(0, 1)),
                12'($urandom_range(0, 4095)), 13'($urandom_range(0, 8191)));
        if (pick < 6)
            h.opcode = OP_TICK;
        else if (pick < 11)
        begin
            h.checksum_ok = 1'b0;
            h.seq_num     = 16'($urandom);
            {h.pkt_syn, h.pkt_fin, h.pkt_str, h.pkt_end} = 4'($urandom);
        end
        else if (pick < 16)
            h.seq_num = tracker.exp_seq ^ 16'($urandom_range(1, 65535));
        else if (pick < 20)
            {h.pkt_syn, h.pkt_fin, h.pkt_str, h.pkt_end} = 4'($urandom);
        else if (!tracker.mode[ON_BIT])
            h.pkt_syn = (roll < 90);
        else if (!tracker.mode[SEND_BIT])
        begin
            if (roll < 75)
            begin
                h.pkt_str = 1'b1;
                // mostly short files so that they finish
                if (roll < 70)
                    h.chunk_total = 12'($urandom_range(0, 8));
            end
            else if (roll < 85)
                h.pkt_fin = 1'b1;
        end
        else if (tracker.seen < tracker.last_idx)
        begin
            if (roll < 4)
                h.pkt_end = 1'b1;
            else if (roll < 6)
                h.pkt_fin = 1'b1;
        end
        else
        begin
            if (roll < 85)
                h.pkt_end = 1'b1;
            else if (roll < 92)
                h.pkt_fin = 1'b1;
        end
        return h;
    endfunction

    task automatic send_word(input header_t h);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, h.final_len, h.chunk_total, h.seq_num, h.checksum_ok};
        s_axis_tuser  <= {h.pkt_cont, h.pkt_str, h.pkt_fin, h.pkt_syn, h.opcode};
        s_axis_tlast  <= h.pkt_end;
        do @(posedge clk); while (!s_axis_tready);
        tracker.take_word(h);
    endtask

    task automatic wait_for_replies();
        s_axis_tvalid <= 1'b0;
        while (tracker.due.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic addr, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        tracker.write_reg(addr, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_tick();
        header_t h;
        h = pkt(1'b0, 1'b0, 1'b0, 1'b0, 1'($urandom_range(0, 1)),
                12'($urandom), 13'($urandom));
        h.opcode = OP_TICK;
        send_word(h);
    endtask

    initial
    begin
        header_t h;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: rejects and stray flags while closed
        send_tick();
        h = pkt(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0, 13'd0);
        h.checksum_ok = 1'b0;
        send_word(h);
        h = pkt(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0, 13'd0);
        h.seq_num = 16'hFFFF;
        send_word(h);
        send_word(pkt(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 12'd0, 13'd0));
        send_word(pkt(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 12'd0, 13'd0));
        send_word(pkt(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0, 13'd0));
        // connect, stray SYN, files: good, empty, one with too few chunks
        send_word(pkt(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0, 13'd0));
        send_word(pkt(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0, 13'd0));
        send_word(pkt(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 12'd1, 13'd8191));
        send_word(pkt(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 12'd0, 13'd0));
        send_word(pkt(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 12'd0, 13'd0));
        send_word(pkt(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 12'd0, 13'd0));
        send_word(pkt(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 12'd0, 13'd0));
        send_word(pkt(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 12'd4095, 13'd4096));
        send_word(pkt(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0, 13'd0));
        send_word(pkt(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 12'd0, 13'd0));
        send_word(pkt(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 12'd0, 13'd0));
        // zero timeout drops an open session on the first tick
        wait_for_replies();
        write_reg(CFG_TIMEOUT, 16'd0);
        send_tick();
        send_tick();
        wait_for_replies();
        write_reg(CFG_TIMEOUT, TIMEOUT_RST);
        // file that ends the session, then a new connect and FIN
        send_word(pkt(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0, 13'd0));
        send_word(pkt(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 12'd0, 13'd13));
        send_word(pkt(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 12'd0, 13'd0));
        send_word(pkt(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 12'd0, 13'd0));
        send_word(pkt(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 12'd0, 13'd0));

        for (int p = 0; p < PHASES; p++)
        begin
            wait_for_replies();
            write_reg(CFG_ACK_EVERY, 16'(ack_plan[p]));
            write_reg(CFG_TIMEOUT, tmo_plan[p]);
            src_burst  = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            if (p == 3)
            begin
                src_burst = 1'b1;
                hold_out  = 1'b1;
            end
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (p == 6 && n == PHASE_WORDS / 2)
                    wait_for_replies();
                if ($urandom_range(0, 49) == 0 && tracker.timeout_ticks <= 16'd40)
                    repeat (int'(tracker.timeout_ticks) + 1) send_tick();
                else
                    send_word(random_word());
            end
        end

        wait_for_replies();
        repeat (8) @(posedge clk);
        if (tracker.faults == 0 && tracker.due.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches, %0d replies missing", tracker.faults, tracker.due.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
